FILE: hdl/alu_pkg.sv
// Package with widths, opcodes and stage types for the pipelined arithmetic unit.
`timescale 1ns / 1ps
package alu_pkg;
    localparam int WIDTH = 32;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES = WIDTH / DIV_PER_STAGE;
    localparam int HALF = WIDTH / 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [WIDTH-1:0]  a;
        logic [WIDTH-1:0]  b;
        logic [WIDTH-1:0]  res;
        logic [WIDTH-1:0]  rem;
        logic              ovf;
        logic [WIDTH-1:0]  pp_ll;
        logic [WIDTH-1:0]  pp_x;
    } t_beat;
endpackage

FILE: hdl/alu_div_stage.sv
// One pipeline stage: four restoring division steps plus beat forwarding.
`timescale 1ns / 1ps
module alu_div_stage
    import alu_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic [$clog2(DIV_STAGES)-1:0]   i_idx,
    input  t_beat                           i_beat,
    output t_beat                           o_beat
);
    t_beat r_beat;
    t_beat n_beat;

    always_comb begin
        logic [WIDTH:0]   rr;
        logic [WIDTH-1:0] r;
        logic [WIDTH-1:0] q;
        int               bit_i;
        n_beat = i_beat;
        r = i_beat.rem;
        q = i_beat.res;
        for (int k = 0; k < DIV_PER_STAGE; k++) begin
            bit_i = WIDTH - 1 - (int'(i_idx) * DIV_PER_STAGE + k);
            rr = {r, i_beat.a[bit_i]};
            if (rr >= {1'b0, i_beat.b}) begin
                rr = rr - {1'b0, i_beat.b};
                q[bit_i] = 1'b1;
            end
            r = rr[WIDTH-1:0];
        end
        if (i_beat.op == OP_DIV && i_beat.b != '0) begin
            n_beat.rem = r;
            n_beat.res = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_adv) begin
            r_beat.valid <= n_beat.valid;
        end
        if (i_adv) begin
            r_beat.op    <= n_beat.op;
            r_beat.a     <= n_beat.a;
            r_beat.b     <= n_beat.b;
            r_beat.res   <= n_beat.res;
            r_beat.rem   <= n_beat.rem;
            r_beat.ovf   <= n_beat.ovf;
            r_beat.pp_ll <= n_beat.pp_ll;
            r_beat.pp_x  <= n_beat.pp_x;
        end
    end

    assign o_beat = r_beat;
endmodule

FILE: hdl/fixed_width_add_sub_mul_div_unit_core.sv
// Top level of the pipelined add, subtract, multiply and divide unit.
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_op, i_operand_a, i_operand_b
//  output  | o_valid | i_stall | o_result, o_remainder_out, o_overflow
// One beat enters every cycle while o_stall is low.
// Stage 0 does add/sub, partial products and division setup; eight stages
// run four restoring divide steps each; the last stage sums the product.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears all valid bits.
`timescale 1ns / 1ps
module fixed_width_add_sub_mul_div_unit_core
    import alu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result,
    output logic [31:0] o_remainder_out,
    output logic        o_overflow
);
    t_beat            r_s0;
    t_beat            w_st [DIV_STAGES+1];
    logic             w_adv;
    logic             r_valid;
    logic [WIDTH-1:0] r_res;
    logic [WIDTH-1:0] r_rem;
    logic             r_ovf;
    logic [WIDTH-1:0] w_sum;
    logic [WIDTH-1:0] w_diff;
    logic [WIDTH-1:0] w_mul;
    t_beat            w_last;

    assign w_adv   = !r_valid || !i_stall;
    assign o_stall = !w_adv;

    assign w_sum  = i_operand_a + i_operand_b;
    assign w_diff = i_operand_a - i_operand_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_adv) begin
            r_s0.valid <= i_valid;
        end
        if (w_adv) begin
            r_s0.op    <= t_op'(i_op);
            r_s0.a     <= i_operand_a;
            r_s0.b     <= i_operand_b;
            r_s0.pp_ll <= WIDTH'(i_operand_a[HALF-1:0]) * WIDTH'(i_operand_b[HALF-1:0]);
            r_s0.pp_x  <= WIDTH'(i_operand_a[WIDTH-1:HALF]) * WIDTH'(i_operand_b[HALF-1:0])
                        + WIDTH'(i_operand_a[HALF-1:0]) * WIDTH'(i_operand_b[WIDTH-1:HALF]);
            unique case (t_op'(i_op))
                OP_ADD: begin
                    r_s0.res <= w_sum;
                    r_s0.rem <= '0;
                    r_s0.ovf <= (i_operand_a[WIDTH-1] ^ w_sum[WIDTH-1])
                              & (i_operand_b[WIDTH-1] ^ w_sum[WIDTH-1]);
                end
                OP_SUB: begin
                    r_s0.res <= w_diff;
                    r_s0.rem <= '0;
                    r_s0.ovf <= (i_operand_a[WIDTH-1] ^ i_operand_b[WIDTH-1])
                              & (i_operand_a[WIDTH-1] ^ w_diff[WIDTH-1]);
                end
                OP_MUL: begin
                    r_s0.res <= '0;
                    r_s0.rem <= '0;
                    r_s0.ovf <= 1'b0;
                end
                default: begin
                    // Division by zero keeps these values through the divide stages.
                    r_s0.res <= (i_operand_b == '0) ? '1 : '0;
                    r_s0.rem <= (i_operand_b == '0) ? i_operand_a : '0;
                    r_s0.ovf <= 1'b0;
                end
            endcase
        end
    end

    assign w_st[0] = r_s0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        alu_div_stage u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_idx  (($clog2(DIV_STAGES))'(g)),
            .i_beat (w_st[g]),
            .o_beat (w_st[g+1])
        );
    end

    assign w_last = w_st[DIV_STAGES];
    assign w_mul  = w_last.pp_ll + {w_last.pp_x[HALF-1:0], {HALF{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= w_last.valid;
        end
        if (w_adv) begin
            r_res <= (w_last.op == OP_MUL) ? w_mul : w_last.res;
            r_rem <= w_last.rem;
            r_ovf <= w_last.ovf;
        end
    end

    assign o_valid         = r_valid;
    assign o_result        = r_res;
    assign o_remainder_out = r_rem;
    assign o_overflow      = r_ovf;
endmodule
